[rtl/bmm_pkg.sv]
// Package with shared constants for the bipartite matching block.
`timescale 1ns / 1ps
package bmm_pkg;
    localparam int LEFT_MAX_DEF  = 16;
    localparam int RIGHT_MAX_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [0:0] REG_LEFT_COUNT  = 1'b0;
    localparam logic [0:0] REG_RIGHT_COUNT = 1'b1;
endpackage

[rtl/bmm_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/bipartite_max_matching_top.sv]
// Top level of the bipartite maximum matching engine.
// Add: the row is written the next cycle while input is held off; clear drops graph and matching.
// Run: each search walks a queue seeded with the free left vertices and scans one adjacency bit
// per cycle, then follows the augmenting path step by step on success; a run makes one search
// more than it has augmentations. Emit walks the left vertices and can be held by output stalls.
// One item is worked on at a time. Reset empties graph and matching.
`timescale 1ns / 1ps
module bipartite_max_matching_top
    import bmm_pkg::*;
#(
    parameter int LEFT_MAX  = bmm_pkg::LEFT_MAX_DEF,
    parameter int RIGHT_MAX = bmm_pkg::RIGHT_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [3:0] left_vertex,
    input  logic [3:0] right_vertex,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] pair_left,
    output logic [3:0] pair_right,
    output logic       pair_valid,
    output logic [4:0] match_count,
    output logic       last
);
    localparam int LW = $clog2(LEFT_MAX);
    localparam int RW = $clog2(RIGHT_MAX);
    localparam int LCW = $clog2(LEFT_MAX + 1);
    localparam int RCW = $clog2(RIGHT_MAX + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_POP, S_POPW, S_SCAN, S_SCANW, S_AUG, S_AUGW,
        S_EMIT, S_EMITW, S_OUT
    } state_t;

    state_t state_reg;
    logic [4:0] lcnt_reg, rcnt_reg;
    logic [LEFT_MAX-1:0]  row_valid_reg;
    logic [LEFT_MAX-1:0]  lmatch_reg, seen_reg;
    logic [RIGHT_MAX-1:0] rmatch_reg, visited_reg;
    logic [RIGHT_MAX-1:0][LW-1:0] partner_reg;
    logic [RIGHT_MAX-1:0][LW-1:0] parent_reg;
    logic [LEFT_MAX-1:0][LW-1:0]  queue_reg;
    logic [LCW-1:0] head_reg, tail_reg, lidx_reg;
    logic [RCW-1:0] v_reg;
    logic [LW-1:0]  u_reg;
    logic [7:0]     total_reg;
    logic [4:0]     nemit_reg;
    logic           any_reg;
    logic [3:0]     hold_l_reg, hold_r_reg;

    logic [LCW-1:0] nl;
    logic [RCW-1:0] nr;
    assign nl = (32'(lcnt_reg) > LEFT_MAX)  ? LCW'(LEFT_MAX)  : LCW'(lcnt_reg);
    assign nr = (32'(rcnt_reg) > RIGHT_MAX) ? RCW'(RIGHT_MAX) : RCW'(rcnt_reg);

    logic              adj_we;
    logic [LW-1:0]     adj_waddr, adj_raddr;
    logic [RIGHT_MAX-1:0] adj_wdata, adj_rdata, row_q;

    bmm_ram #(.WIDTH(RIGHT_MAX), .DEPTH(LEFT_MAX)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );

    logic add_pend_reg;
    logic [LW-1:0] add_l_reg;
    logic [RW-1:0] add_r_reg;

    logic add_ok;
    assign add_ok = (32'(left_vertex) < LEFT_MAX) && (32'(right_vertex) < RIGHT_MAX);
    logic in_fire;
    assign in_ready = (state_reg == S_IDLE) && !out_valid && !add_pend_reg;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        adj_we    = 1'b0;
        adj_waddr = add_l_reg;
        adj_wdata = (row_valid_reg[add_l_reg] ? adj_rdata : '0);
        adj_wdata[add_r_reg] = 1'b1;
        if (add_pend_reg)
        begin
            adj_we = 1'b1;
        end
        adj_raddr = u_reg;
        if (in_fire && mode == MODE_ADD)
        begin
            adj_raddr = LW'(left_vertex);
        end
    end
    assign row_q = row_valid_reg[u_reg] ? adj_rdata : '0;

    logic          stop;
    logic [RW-1:0] found_r;
    logic          partner_found;
    logic [LW-1:0] want;
    logic          scan_hit;
    logic          emit_done;
    logic          out_free;
    logic          out_load;
    logic [4:0]    count_sat;

    // partner search for augmentation and emission
    always_comb
    begin
        want = (state_reg == S_AUG) ? parent_reg[RW'(v_reg)] :
               ((state_reg == S_EMITW) ? LW'(lidx_reg - 1'b1) : LW'(lidx_reg));
        found_r = '0;
        partner_found = 1'b0;
        for (int r = RIGHT_MAX - 1; r >= 0; r--)
        begin
            if (rmatch_reg[r] && partner_reg[r] == want)
            begin
                found_r = RW'(r);
                partner_found = 1'b1;
            end
        end
        stop = !lmatch_reg[want] || !partner_found;
    end

    assign scan_hit = row_q[RW'(v_reg)] && !visited_reg[RW'(v_reg)] &&
                      !(rmatch_reg[RW'(v_reg)] && partner_reg[RW'(v_reg)] == u_reg);
    assign emit_done = (lidx_reg >= LCW'(LEFT_MAX)) || (nemit_reg >= 5'(MAX_RESULTS));
    assign out_free  = !out_valid || out_ready;
    assign count_sat = (total_reg > 8'd31) ? 5'd31 : 5'(total_reg);

    always_comb
    begin
        out_load = 1'b0;
        if (state_reg == S_EMITW && any_reg && out_free)
        begin
            out_load = 1'b1;
        end
        if (state_reg == S_EMIT && emit_done && out_free)
        begin
            out_load = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lcnt_reg      <= 5'd16;
            rcnt_reg      <= 5'd16;
            row_valid_reg <= '0;
            lmatch_reg    <= '0;
            rmatch_reg    <= '0;
            seen_reg      <= '0;
            visited_reg   <= '0;
            partner_reg   <= '0;
            parent_reg    <= '0;
            queue_reg     <= '0;
            total_reg     <= '0;
            out_valid     <= 1'b0;
            add_pend_reg  <= 1'b0;
            add_l_reg     <= '0;
            add_r_reg     <= '0;
            pair_left     <= '0;
            pair_right    <= '0;
            pair_valid    <= 1'b0;
            match_count   <= '0;
            last          <= 1'b0;
            hold_l_reg    <= '0;
            hold_r_reg    <= '0;
            head_reg <= '0; tail_reg <= '0; lidx_reg <= '0; v_reg <= '0; u_reg <= '0;
            nemit_reg <= '0; any_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_LEFT_COUNT) lcnt_reg <= cfg_data;
                else rcnt_reg <= cfg_data;
            end
            if (add_pend_reg)
            begin
                add_pend_reg <= 1'b0;
                row_valid_reg[add_l_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (mode == MODE_ADD && add_ok)
                        begin
                            add_pend_reg <= 1'b1;
                            add_l_reg <= LW'(left_vertex);
                            add_r_reg <= RW'(right_vertex);
                        end
                        else if (mode == MODE_CLEAR)
                        begin
                            row_valid_reg <= '0;
                            lmatch_reg <= '0;
                            rmatch_reg <= '0;
                            total_reg <= '0;
                        end
                        else if (mode == MODE_RUN)
                        begin
                            state_reg <= S_INIT;
                            lidx_reg <= '0;
                            tail_reg <= '0;
                            head_reg <= '0;
                            seen_reg <= '0;
                            visited_reg <= '0;
                        end
                    end
                end
                S_INIT:
                begin
                    if (lidx_reg < nl)
                    begin
                        if (!lmatch_reg[LW'(lidx_reg)])
                        begin
                            queue_reg[LW'(tail_reg)] <= LW'(lidx_reg);
                            tail_reg <= tail_reg + 1'b1;
                            seen_reg[LW'(lidx_reg)] <= 1'b1;
                        end
                        lidx_reg <= lidx_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (head_reg < tail_reg)
                    begin
                        u_reg <= queue_reg[LW'(head_reg)];
                        head_reg <= head_reg + 1'b1;
                        v_reg <= '0;
                        state_reg <= S_POPW;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                        lidx_reg <= '0;
                        nemit_reg <= '0;
                        any_reg <= 1'b0;
                    end
                end
                S_POPW:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (v_reg >= nr)
                    begin
                        state_reg <= S_POP;
                    end
                    else if (scan_hit && !rmatch_reg[RW'(v_reg)])
                    begin
                        visited_reg[RW'(v_reg)] <= 1'b1;
                        parent_reg[RW'(v_reg)] <= u_reg;
                        state_reg <= S_AUG;
                    end
                    else
                    begin
                        v_reg <= v_reg + 1'b1;
                        if (scan_hit)
                        begin
                            visited_reg[RW'(v_reg)] <= 1'b1;
                            parent_reg[RW'(v_reg)] <= u_reg;
                            if (!seen_reg[partner_reg[RW'(v_reg)]] &&
                                tail_reg < LCW'(LEFT_MAX))
                            begin
                                seen_reg[partner_reg[RW'(v_reg)]] <= 1'b1;
                                queue_reg[LW'(tail_reg)] <= partner_reg[RW'(v_reg)];
                                tail_reg <= tail_reg + 1'b1;
                            end
                        end
                    end
                end
                S_AUG:
                begin
                    partner_reg[RW'(v_reg)] <= parent_reg[RW'(v_reg)];
                    rmatch_reg[RW'(v_reg)] <= 1'b1;
                    if (stop)
                    begin
                        lmatch_reg[parent_reg[RW'(v_reg)]] <= 1'b1;
                        if (total_reg != 8'hFF) total_reg <= total_reg + 1'b1;
                        state_reg <= S_INIT;
                        lidx_reg <= '0;
                        tail_reg <= '0;
                        head_reg <= '0;
                        seen_reg <= '0;
                        visited_reg <= '0;
                    end
                    else
                    begin
                        v_reg <= RCW'(found_r);
                    end
                end
                S_EMIT:
                begin
                    if (emit_done)
                    begin
                        if (out_free)
                        begin
                            pair_left   <= any_reg ? hold_l_reg : 4'd0;
                            pair_right  <= any_reg ? hold_r_reg : 4'd0;
                            pair_valid  <= any_reg;
                            match_count <= any_reg ? count_sat : 5'd0;
                            last        <= 1'b1;
                            state_reg   <= S_OUT;
                        end
                    end
                    else
                    begin
                        lidx_reg <= lidx_reg + 1'b1;
                        if (lmatch_reg[LW'(lidx_reg)] && partner_found)
                        begin
                            state_reg <= S_EMITW;
                        end
                    end
                end
                S_EMITW:
                begin
                    if (!any_reg)
                    begin
                        hold_l_reg <= 4'(lidx_reg - 1'b1);
                        hold_r_reg <= 4'(found_r);
                        any_reg <= 1'b1;
                        nemit_reg <= nemit_reg + 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else if (out_free)
                    begin
                        pair_left   <= hold_l_reg;
                        pair_right  <= hold_r_reg;
                        pair_valid  <= 1'b1;
                        match_count <= count_sat;
                        last        <= 1'b0;
                        hold_l_reg  <= 4'(lidx_reg - 1'b1);
                        hold_r_reg  <= 4'(found_r);
                        nemit_reg   <= nemit_reg + 1'b1;
                        state_reg   <= S_EMIT;
                    end
                end
                S_OUT:
                begin
                    if (out_valid && out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

[rtl/bmm_checker.sv]
// Port-level checker for the bipartite matching block, bound to the top level.
`timescale 1ns / 1ps
module bmm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       pair_valid,
    input logic       last,
    input logic [4:0] match_count
);
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input item withdrawn while waiting");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pair_valid |-> last && match_count == 5'd0)
        else $error("empty result not final");
    a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_valid |-> match_count != 5'd0)
        else $error("pair with zero count");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
endmodule

bind bipartite_max_matching_top bmm_checker u_bmm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .pair_valid(pair_valid),
    .last(last), .match_count(match_count)
);

[tb/bipartite_max_matching_top_test.sv]
// Randomized testbench for the bipartite maximum matching block, checked against a matching predictor.
`timescale 1ns / 1ps
module bipartite_max_matching_top_test;
    import bmm_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [3:0] pl;
        logic [3:0] pr;
        logic       pv;
        logic [4:0] cnt;
        logic       lst;
    } pair_item_t;

    class matching_scoreboard;
        logic [15:0] adj [16];
        logic [3:0]  right_owner [16];
        logic [15:0] right_taken;
        logic [15:0] left_taken;
        int          pairs_made;
        int          n_left;
        int          n_right;
        pair_item_t  pending [$];
        int          errors;

        function void clear_graph();
            for (int i = 0; i < 16; i++)
            begin
                adj[i] = '0;
                right_owner[i] = '0;
            end
            right_taken = '0;
            left_taken = '0;
            pairs_made = 0;
        endfunction

        function bit search_path(output int end_r, ref logic [3:0] parent [16]);
            logic [3:0]  q [$];
            logic [15:0] seen_l;
            logic [15:0] seen_r;
            int u;
            seen_l = '0;
            seen_r = '0;
            for (int i = 0; i < n_left; i++)
            begin
                if (!left_taken[i])
                begin
                    q = {q, i[3:0]};
                    seen_l[i] = 1'b1;
                end
            end
            while (q.size() > 0)
            begin
                u = q.pop_front();
                for (int v = 0; v < n_right; v++)
                begin
                    if (!adj[u][v] || seen_r[v])
                        continue;
                    if (right_taken[v] && right_owner[v] == u)
                        continue;
                    seen_r[v] = 1'b1;
                    parent[v] = u[3:0];
                    if (!right_taken[v])
                    begin
                        end_r = v;
                        return 1'b1;
                    end
                    if (!seen_l[right_owner[v]])
                    begin
                        seen_l[right_owner[v]] = 1'b1;
                        q = {q, right_owner[v]};
                    end
                end
            end
            return 1'b0;
        endfunction

        function void augment_path(int v, ref logic [3:0] parent [16]);
            int u;
            int old;
            for (int s = 0; s <= 16; s++)
            begin
                u = parent[v];
                old = 16;
                if (left_taken[u])
                begin
                    for (int r = 0; r < 16; r++)
                    begin
                        if (right_taken[r] && right_owner[r] == u)
                        begin
                            old = r;
                            break;
                        end
                    end
                end
                right_owner[v] = u[3:0];
                right_taken[v] = 1'b1;
                if (old >= 16)
                begin
                    left_taken[u] = 1'b1;
                    break;
                end
                v = old;
            end
            pairs_made++;
        endfunction

        function void note_item(logic [1:0] m, logic [3:0] lv, logic [3:0] rv);
            logic [3:0] parent [16];
            int e;
            int v;
            int n;
            pair_item_t it;
            if (m == MODE_ADD)
                adj[lv][rv] = 1'b1;
            else if (m == MODE_CLEAR)
                clear_graph();
            else if (m == MODE_RUN)
            begin
                while (search_path(e, parent))
                    augment_path(e, parent);
                n = 0;
                for (int u = 0; u < 16; u++)
                begin
                    if (!left_taken[u])
                        continue;
                    for (v = 0; v < 16; v++)
                        if (right_taken[v] && right_owner[v] == u)
                            break;
                    if (v >= 16)
                        continue;
                    it.pl = u[3:0];
                    it.pr = v[3:0];
                    it.pv = 1'b1;
                    it.cnt = pairs_made > 31 ? 5'd31 : pairs_made[4:0];
                    it.lst = 1'b0;
                    pending = {pending, it};
                    n++;
                end
                if (n == 0)
                begin
                    it = '{pl: 4'd0, pr: 4'd0, pv: 1'b0, cnt: 5'd0, lst: 1'b1};
                    pending = {pending, it};
                end
                else
                    pending[pending.size() - 1].lst = 1'b1;
            end
        endfunction

        function void check_result(pair_item_t got);
            pair_item_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected item: actual %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.pl !== got.pl || want.pr !== got.pr || want.pv !== got.pv ||
                want.cnt !== got.cnt || want.lst !== got.lst)
            begin
                $display("%0t mismatch: expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [4:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] mode;
    logic [3:0] left_vertex;
    logic [3:0] right_vertex;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] pair_left;
    logic [3:0] pair_right;
    logic       pair_valid;
    logic [4:0] match_count;
    logic       last;

    matching_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycle_count = 0;

    bipartite_max_matching_top dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result('{pl: pair_left, pr: pair_right, pv: pair_valid,
                                 cnt: match_count, lst: last});
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(logic [1:0] m, logic [3:0] lv, logic [3:0] rv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        left_vertex <= lv;
        right_vertex <= rv;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_item(m, lv, rv);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (2000)
            @(posedge clk);
    endtask

    task automatic write_counts(int nl, int nr);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_LEFT_COUNT;
        cfg_data <= nl[4:0];
        @(posedge clk);
        cfg_index <= REG_RIGHT_COUNT;
        cfg_data <= nr[4:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        board.n_left = nl > 16 ? 16 : nl;
        board.n_right = nr > 16 ? 16 : nr;
    endtask

    task automatic random_graph(int edges, int density);
        int k;
        k = $urandom_range(99);
        if (k < 10)
            send_item(MODE_CLEAR, 4'($urandom), 4'($urandom));
        else if (k < 13)
            send_item(MODE_SPARE, 4'($urandom), 4'($urandom));
        for (int i = 0; i < edges; i++)
            send_item(MODE_ADD, 4'($urandom_range(density)), 4'($urandom_range(density)));
        send_item(MODE_RUN, 4'($urandom), 4'($urandom));
    endtask

    initial
    begin
        board = new();
        board.clear_graph();
        board.n_left = 16;
        board.n_right = 16;
        board.errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = '0;
        left_vertex = '0;
        right_vertex = '0;
        out_ready = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_RUN, 4'd0, 4'd0);
        send_item(MODE_ADD, 4'd15, 4'd15);
        send_item(MODE_ADD, 4'd0, 4'd0);
        send_item(MODE_ADD, 4'd0, 4'd15);
        send_item(MODE_ADD, 4'd15, 4'd0);
        send_item(MODE_SPARE, 4'd5, 4'd5);
        send_item(MODE_RUN, 4'd15, 4'd15);
        send_item(MODE_ADD, 4'd1, 4'd0);
        send_item(MODE_ADD, 4'd2, 4'd0);
        send_item(MODE_ADD, 4'd2, 4'd1);
        send_item(MODE_RUN, 4'd0, 4'd0);
        write_counts(1, 1);
        send_item(MODE_CLEAR, 4'd0, 4'd0);
        send_item(MODE_ADD, 4'd0, 4'd0);
        send_item(MODE_ADD, 4'd1, 4'd1);
        send_item(MODE_RUN, 4'd0, 4'd0);
        write_counts(0, 16);
        send_item(MODE_RUN, 4'd0, 4'd0);
        write_counts(31, 31);
        for (int i = 0; i < 16; i++)
            send_item(MODE_ADD, i[3:0], i[3:0]);
        send_item(MODE_RUN, 4'd0, 4'd0);
        write_counts(16, 16);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 52; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 52; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 4)
                write_counts($urandom_range(1, 15), $urandom_range(1, 15));
            else if (ph == 6)
                write_counts(16, $urandom_range(17, 31));
            for (int g = 0; g < 3; g++)
                random_graph($urandom_range(4, 12), $urandom_range(3, 15));
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[files.f]
rtl/bmm_pkg.sv
rtl/bmm_ram.sv
rtl/bipartite_max_matching_top.sv
rtl/bmm_checker.sv
tb/bipartite_max_matching_top_test.sv
